/* rtl/core/sorted_timer_queue_defines.svh */
// ----------------------------------------------------------------------------
// sorted_timer_queue_defines
// assertion macros used by the timer queue checker
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define STQ_ASSERT_IMPL(lbl, clk_i, rst_ni, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is held
`define STQ_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/stq_pkg.sv */
// ----------------------------------------------------------------------------
// stq_pkg
// shared types and constants of the sorted timer queue
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  localparam int unsigned ID_W   = 10;
  localparam int unsigned TIME_W = 32;

  // operation codes of the input word
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;     // take the input word
    logic rd_head;     // read the head slot
    logic walk_start;  // set up the backward walk from the tail
    logic walk_step;   // move the slot just read up by one, step back
    logic wr_new;      // write the new entry at the destination slot
    logic set_rej;     // flag the insert as rejected
    logic pop_take;    // take the head entry, advance the head
    logic inc_count;   // one more entry held
    logic load_out;    // load the result word into the output register
  } stq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic kind_pop;
    logic count_zero;
    logic count_full;
    logic rd_less;     // slot just read is earlier than the new entry
    logic walk_last;   // slot just read is the head slot
  } stq_stat_t;

endpackage

`default_nettype wire

/* rtl/core/stq_ctrl.sv */
// ----------------------------------------------------------------------------
// stq_ctrl
// sequencer of the sorted timer queue: handshakes and per-operation steps
// ----------------------------------------------------------------------------
`default_nettype none

module stq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire stq_pkg::stq_stat_t stat,
  output stq_pkg::stq_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_START    = 3'd1;
  localparam logic [2:0] ST_INS_CMP  = 3'd2;
  localparam logic [2:0] ST_INS_LAST = 3'd3;
  localparam logic [2:0] ST_POP_WAIT = 3'd4;
  localparam logic [2:0] ST_RESULT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_START;
        end
      end
      ST_START: begin
        if (stat.kind_pop) begin
          if (stat.count_zero) begin
            state_nxt = ST_RESULT;
          end else begin
            cmd.rd_head = 1'b1;
            state_nxt   = ST_POP_WAIT;
          end
        end else if (stat.count_full) begin
          cmd.set_rej = 1'b1;
          state_nxt   = ST_RESULT;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = stat.count_zero ? ST_INS_LAST : ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (stat.rd_less) begin
          cmd.wr_new    = 1'b1;
          cmd.inc_count = 1'b1;
          state_nxt     = ST_RESULT;
        end else begin
          cmd.walk_step = 1'b1;
          if (stat.walk_last) begin
            state_nxt = ST_INS_LAST;
          end
        end
      end
      ST_INS_LAST: begin
        cmd.wr_new    = 1'b1;
        cmd.inc_count = 1'b1;
        state_nxt     = ST_RESULT;
      end
      ST_POP_WAIT: begin
        cmd.pop_take = 1'b1;
        state_nxt    = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/stq_dp.sv */
// ----------------------------------------------------------------------------
// stq_dp
// datapath of the sorted timer queue: circular slot memory, pointers, result
// ----------------------------------------------------------------------------
`default_nettype none

module stq_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire stq_pkg::stq_cmd_t           cmd,
  output stq_pkg::stq_stat_t               stat,
  input  wire logic                        in_kind,
  input  wire logic [stq_pkg::ID_W-1:0]    in_proc_id,
  input  wire logic [stq_pkg::TIME_W-1:0]  in_wake_time,
  output logic                             out_popped_valid,
  output logic [stq_pkg::ID_W-1:0]         out_popped_id,
  output logic [stq_pkg::TIME_W-1:0]       out_popped_time,
  output logic                             out_insert_rejected,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] out_entry_count,
  output logic                             out_queue_empty
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  // slot memory, one write and one registered read per cycle
  logic [stq_pkg::ID_W-1:0]   mem_id   [QUEUE_DEPTH];
  logic [stq_pkg::TIME_W-1:0] mem_time [QUEUE_DEPTH];

  logic                        kind_r;
  logic [stq_pkg::ID_W-1:0]    id_r;
  logic [stq_pkg::TIME_W-1:0]  time_r;
  logic [AW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [AW-1:0]               dst_r, p_r;
  logic [CW-1:0]               rem_r;
  logic [stq_pkg::ID_W-1:0]    rd_id_r;
  logic [stq_pkg::TIME_W-1:0]  rd_time_r;
  logic                        res_pv_r, res_rej_r;
  logic [stq_pkg::ID_W-1:0]    res_id_r;
  logic [stq_pkg::TIME_W-1:0]  res_time_r;
  logic                        o_pv_r, o_rej_r, o_empty_r;
  logic [stq_pkg::ID_W-1:0]    o_id_r;
  logic [stq_pkg::TIME_W-1:0]  o_time_r;
  logic [CW-1:0]               o_count_r;

  logic [SW-1:0]               tail_sum;
  logic [AW-1:0]               tail_dst, tail_prev, p_prev, rd_addr, wr_addr;
  logic                        wr_en;
  logic [stq_pkg::ID_W-1:0]    wr_id;
  logic [stq_pkg::TIME_W-1:0]  wr_time;

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == '0) begin
      r = AW'(QUEUE_DEPTH - 1);
    end else begin
      r = p - AW'(1);
    end
    return r;
  endfunction

  // first free slot after the tail, wrapped once
  always_comb begin
    tail_sum = SW'(head_r) + SW'(count_r);
    if (tail_sum >= SW'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SW'(QUEUE_DEPTH);
    end
    tail_dst  = tail_sum[AW-1:0];
    tail_prev = ptr_dec(tail_dst);
    p_prev    = ptr_dec(p_r);
  end

  always_comb begin
    if (cmd.rd_head) begin
      rd_addr = head_r;
    end else if (cmd.walk_start) begin
      rd_addr = tail_prev;
    end else begin
      rd_addr = p_prev;
    end
    wr_en   = cmd.wr_new | cmd.walk_step;
    wr_addr = dst_r;
    wr_id   = cmd.wr_new ? id_r : rd_id_r;
    wr_time = cmd.wr_new ? time_r : rd_time_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr]   <= wr_id;
      mem_time[wr_addr] <= wr_time;
    end
    rd_id_r   <= mem_id[rd_addr];
    rd_time_r <= mem_time[rd_addr];
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.pop_take) begin
      head_nxt  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
      count_nxt = count_r - CW'(1);
    end else if (cmd.inc_count) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // operation registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r    <= in_kind;
      id_r      <= in_proc_id;
      time_r    <= in_wake_time;
      res_pv_r  <= 1'b0;
      res_rej_r <= 1'b0;
      res_id_r  <= '0;
      res_time_r <= '0;
    end
    if (cmd.set_rej) begin
      res_rej_r <= 1'b1;
    end
    if (cmd.pop_take) begin
      res_pv_r   <= 1'b1;
      res_id_r   <= rd_id_r;
      res_time_r <= rd_time_r;
    end
    if (cmd.walk_start) begin
      dst_r <= tail_dst;
      p_r   <= tail_prev;
      rem_r <= count_r;
    end else if (cmd.walk_step) begin
      dst_r <= p_r;
      p_r   <= p_prev;
      rem_r <= rem_r - CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_pv_r    <= res_pv_r;
      o_id_r    <= res_id_r;
      o_time_r  <= res_time_r;
      o_rej_r   <= res_rej_r;
      o_count_r <= count_r;
      o_empty_r <= (count_r == '0);
    end
  end

  assign stat.kind_pop   = (kind_r == stq_pkg::KIND_POP);
  assign stat.count_zero = (count_r == '0);
  assign stat.count_full = (count_r == CW'(QUEUE_DEPTH));
  assign stat.rd_less    = (rd_time_r < time_r);
  assign stat.walk_last  = (rem_r == CW'(1));

  assign out_popped_valid    = o_pv_r;
  assign out_popped_id       = o_id_r;
  assign out_popped_time     = o_time_r;
  assign out_insert_rejected = o_rej_r;
  assign out_entry_count     = o_count_r;
  assign out_queue_empty     = o_empty_r;

endmodule

`default_nettype wire

/* rtl/core/sorted_timer_queue.sv */
// ----------------------------------------------------------------------------
// sorted_timer_queue
// timer list kept in ascending wakeup-time order, insert and pop-earliest
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            word
//   in_       input      in_valid / in_ready   kind, proc_id, wake_time
//   out_      output     out_valid / out_ready popped entry, reject, count
//
// - a pop reads the head slot, then takes the head entry, advancing the head
// - an insert walks back from the tail over the held entries at or after
//   the new wakeup time, one slot per cycle over the single read port
//   of the slot memory
// - a rejected insert or a pop on an empty queue goes straight to the result
// - the next input word can be taken in the cycle after the result is loaded
// - synchronous active-low reset empties the queue, no clearing pass
// - an input word is taken while an earlier result still waits in the
//   output register; the sequencer only holds when a second result is ready
//
`default_nettype none

module sorted_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input words
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_kind,
  input  wire logic [stq_pkg::ID_W-1:0]    in_proc_id,
  input  wire logic [stq_pkg::TIME_W-1:0]  in_wake_time,
  // result words
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_popped_valid,
  output logic [stq_pkg::ID_W-1:0]         out_popped_id,
  output logic [stq_pkg::TIME_W-1:0]       out_popped_time,
  output logic                             out_insert_rejected,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] out_entry_count,
  output logic                             out_queue_empty
);

  stq_pkg::stq_cmd_t  cmd;
  stq_pkg::stq_stat_t stat;

  // sequencer: accepts words, steps each operation, loads the result word
  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: slots live in a circular memory, head pointer plus count;
  // an insert walks back from the tail moving later entries up by one,
  // so equal times end up behind the new entry
  stq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_kind             (in_kind),
    .in_proc_id          (in_proc_id),
    .in_wake_time        (in_wake_time),
    .out_popped_valid    (out_popped_valid),
    .out_popped_id       (out_popped_id),
    .out_popped_time     (out_popped_time),
    .out_insert_rejected (out_insert_rejected),
    .out_entry_count     (out_entry_count),
    .out_queue_empty     (out_queue_empty)
  );

endmodule

`default_nettype wire

/* rtl/core/stq_checker.sv */
// ----------------------------------------------------------------------------
// stq_checker
// port-level checks of the sorted timer queue, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_timer_queue_defines.svh"

module stq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_popped_valid,
  input wire logic [stq_pkg::ID_W-1:0]    out_popped_id,
  input wire logic [stq_pkg::TIME_W-1:0]  out_popped_time,
  input wire logic                        out_insert_rejected,
  input wire logic [$clog2(QUEUE_DEPTH+1)-1:0] out_entry_count,
  input wire logic                        out_queue_empty
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // stalled result word holds its valid, id, time and count
  `STQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_popped_id) && $stable(out_popped_time) && $stable(out_entry_count),
    "result word changed while stalled")

  `STQ_ASSERT_IMPL(a_empty_flag, clk, rst_n, out_valid,
    out_queue_empty == (out_entry_count == '0), "empty flag disagrees with count")

  `STQ_ASSERT_IMPL(a_pop_or_rej, clk, rst_n, out_valid,
    !(out_popped_valid && out_insert_rejected), "pop and reject in one word")

  `STQ_ASSERT_IMPL(a_rej_full, clk, rst_n, out_valid && out_insert_rejected,
    out_entry_count == CW'(QUEUE_DEPTH), "reject reported with queue not full")

  `STQ_ASSERT_IMPL(a_count_max, clk, rst_n, out_valid,
    out_entry_count <= CW'(QUEUE_DEPTH), "entry count above depth")

endmodule

bind sorted_timer_queue stq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_stq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_popped_valid    (out_popped_valid),
  .out_popped_id       (out_popped_id),
  .out_popped_time     (out_popped_time),
  .out_insert_rejected (out_insert_rejected),
  .out_entry_count     (out_entry_count),
  .out_queue_empty     (out_queue_empty)
);

`default_nettype wire
